### design/egf_pkg.sv
// ----------------------------------------------------------------------------
// egf_pkg
// Shared types and constants of the extent gap finder: record kind codes,
// field widths, the configuration reset value and the result record.
// ----------------------------------------------------------------------------
package egf_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned MDSIZE_W  = 17;
  localparam logic [MDSIZE_W-1:0] MDSIZE_RESET = 17'd16384;

  typedef enum logic [1:0] {
    ACT_GROUP = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_META  = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  gap_valid;
    addr_t gap_start;
    addr_t gap_size;
    logic  group_closed;
    logic  overlap_error;
    logic  outside_error;
    logic  misplaced_error;
  } result_t;

endpackage

### design/egf_if.sv
// ----------------------------------------------------------------------------
// egf_if
// Valid/ready channel interfaces of the extent gap finder: record input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface egf_rec_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [egf_pkg::ADDR_W-1:0] record_start;
  logic [egf_pkg::ADDR_W-1:0] record_length;

  modport source (output valid, output action, output record_start,
                  output record_length, input ready);
  modport sink   (input valid, input action, input record_start,
                  input record_length, output ready);
endinterface

interface egf_res_if;
  logic                       valid;
  logic                       ready;
  logic                       gap_valid;
  logic [egf_pkg::ADDR_W-1:0] gap_start;
  logic [egf_pkg::ADDR_W-1:0] gap_size;
  logic                       group_closed;
  logic                       overlap_error;
  logic                       outside_error;
  logic                       misplaced_error;

  modport source (output valid, output gap_valid, output gap_start, output gap_size,
                  output group_closed, output overlap_error, output outside_error,
                  output misplaced_error, input ready);
  modport sink   (input valid, input gap_valid, input gap_start, input gap_size,
                  input group_closed, input overlap_error, input outside_error,
                  input misplaced_error, output ready);
endinterface

interface egf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [egf_pkg::MDSIZE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/extent_gap_finder.sv
// ----------------------------------------------------------------------------
// extent_gap_finder
// Free-gap detector over a start-sorted stream of group, extent and end
// records. Tracks the open group, a placement cursor and one saved extent.
//
//   channel  direction  transaction
//   in_ch    input      one record: action, record_start, record_length
//   out_ch   output     one result per record: gap and error flags
//   cfg_ch   input      metadata extent size write, always ready
//
// One record is taken per cycle unless a result stalls; its result is
// registered in the next cycle. The state update and result come from one
// pass of 64-bit adds, compares and subtracts on the record and stored state.
// A stalled result holds in_ch off only while out_ch is not ready.
// Synchronous reset clears all state but result data and sets size 16384.
// ----------------------------------------------------------------------------
module extent_gap_finder (
  input  logic      clk,
  input  logic      rst_n,
  egf_rec_if.sink   in_ch,
  egf_res_if.source out_ch,
  egf_cfg_if.sink   cfg_ch
);
  import egf_pkg::*;

  logic [MDSIZE_W-1:0] mdsize_r;
  addr_t group_base_r,  group_base_nxt;
  addr_t group_limit_r, group_limit_nxt;
  addr_t cursor_r,      cursor_nxt;
  logic  group_open_r,  group_open_nxt;
  addr_t held_start_r,  held_start_nxt;
  addr_t held_end_r,    held_end_nxt;
  logic  held_valid_r,  held_valid_nxt;

  logic    can_load;
  logic    accept;
  result_t res;
  addr_t   ext_size;
  addr_t   ext_end;
  addr_t   new_limit;
  addr_t   start;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = can_load;
  assign accept       = in_ch.valid && can_load;
  assign start        = in_ch.record_start;

  assign ext_size  = (action_t'(in_ch.action) == ACT_META) ?
                     {{(ADDR_W-MDSIZE_W){1'b0}}, mdsize_r} : in_ch.record_length;
  assign ext_end   = start + ext_size;
  assign new_limit = start + in_ch.record_length;

  always_comb begin
    res             = '0;
    group_base_nxt  = group_base_r;
    group_limit_nxt = group_limit_r;
    cursor_nxt      = cursor_r;
    group_open_nxt  = group_open_r;
    held_start_nxt  = held_start_r;
    held_end_nxt    = held_end_r;
    held_valid_nxt  = held_valid_r;
    unique case (action_t'(in_ch.action))
      ACT_GROUP, ACT_END: begin
        if (group_open_r) begin
          res.group_closed = 1'b1;
          if (cursor_r < group_limit_r) begin
            res.gap_valid = 1'b1;
            res.gap_start = cursor_r;
            res.gap_size  = group_limit_r - cursor_r;
          end
        end
        if (action_t'(in_ch.action) == ACT_GROUP) begin
          group_base_nxt  = start;
          group_limit_nxt = new_limit;
          group_open_nxt  = 1'b1;
          cursor_nxt      = start;
          if (held_valid_r) begin
            if (held_start_r == start) begin
              cursor_nxt = held_end_r;
            end else begin
              res.misplaced_error = 1'b1;
            end
          end
          held_valid_nxt = 1'b0;
        end else begin
          group_base_nxt  = '0;
          group_limit_nxt = '0;
          cursor_nxt      = '0;
          group_open_nxt  = 1'b0;
          held_start_nxt  = '0;
          held_end_nxt    = '0;
          held_valid_nxt  = 1'b0;
        end
      end
      ACT_DATA, ACT_META: begin
        if (start >= group_limit_r) begin
          res.outside_error = held_valid_r;
          held_start_nxt    = start;
          held_end_nxt      = ext_end;
          held_valid_nxt    = 1'b1;
        end else begin
          if (start < cursor_r) begin
            res.overlap_error = 1'b1;
          end else if (start > cursor_r) begin
            res.gap_valid = 1'b1;
            res.gap_start = cursor_r;
            res.gap_size  = start - cursor_r;
          end
          cursor_nxt = ext_end;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mdsize_r      <= MDSIZE_RESET;
      group_base_r  <= '0;
      group_limit_r <= '0;
      cursor_r      <= '0;
      group_open_r  <= 1'b0;
      held_start_r  <= '0;
      held_end_r    <= '0;
      held_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mdsize_r <= cfg_ch.data;
      end
      if (accept) begin
        group_base_r  <= group_base_nxt;
        group_limit_r <= group_limit_nxt;
        cursor_r      <= cursor_nxt;
        group_open_r  <= group_open_nxt;
        held_start_r  <= held_start_nxt;
        held_end_r    <= held_end_nxt;
        held_valid_r  <= held_valid_nxt;
      end
    end
  end

  egf_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_ch.valid),
    .load_data (res),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

endmodule

### design/egf_out_stage.sv
// ----------------------------------------------------------------------------
// egf_out_stage
// Result register of the extent gap finder. Holds one result until the
// downstream side takes it and can reload in the same cycle.
// ----------------------------------------------------------------------------
module egf_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  egf_pkg::result_t load_data,
  output logic             can_load,
  egf_res_if.source        out_ch
);
  import egf_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_r <= load_data;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.gap_valid       = data_r.gap_valid;
  assign out_ch.gap_start       = data_r.gap_start;
  assign out_ch.gap_size        = data_r.gap_size;
  assign out_ch.group_closed    = data_r.group_closed;
  assign out_ch.overlap_error   = data_r.overlap_error;
  assign out_ch.outside_error   = data_r.outside_error;
  assign out_ch.misplaced_error = data_r.misplaced_error;

endmodule
